@@ rtl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    // internal position width: must hold CAPACITY itself
    localparam int IDX_W    = $clog2(CAPACITY + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp;  // capture compare flags against the incoming key
        logic upd;  // apply the insert shift
    } t_cell_ctl;

    // status one cell shows its upper neighbor and the top level
    typedef struct packed {
        logic valid;
        logic lt;   // stored key below the search key
        logic eq;   // stored key equals the search key
        logic bnd;  // this cell is the lower-bound position
    } t_cell_stat;

endpackage

@@ rtl/skt_cell.sv @@
// One table cell: holds an entry, compares it and shifts it up on insert.
module skt_cell
    import skt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_cmp_key,
    input  logic [KEY_W-1:0] i_new_key,
    input  logic [VAL_W-1:0] i_new_value,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [VAL_W-1:0] i_prev_value,
    input  t_cell_stat       i_prev_stat,
    output logic [KEY_W-1:0] o_key,
    output logic [VAL_W-1:0] o_value,
    output t_cell_stat       o_stat
);

    logic [KEY_W-1:0] r_key,   n_key;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_valid, n_valid;
    logic             r_lt, r_eq;
    logic             w_bnd;

    assign w_bnd = i_prev_stat.lt & ~r_lt;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.upd && !r_lt) begin
            if (w_bnd) begin
                n_key   = i_new_key;
                n_value = i_new_value;
                n_valid = 1'b1;
            end else begin
                // take the lower neighbor's entry
                n_key   = i_prev_key;
                n_value = i_prev_value;
                n_valid = i_prev_stat.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.cmp) begin
                r_lt <= r_valid && (r_key < i_cmp_key);
                r_eq <= r_valid && (r_key == i_cmp_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key        = r_key;
    assign o_value      = r_value;
    assign o_stat.valid = r_valid;
    assign o_stat.lt    = r_lt;
    assign o_stat.eq    = r_eq;
    assign o_stat.bnd   = w_bnd;

endmodule

@@ rtl/sorted_key_table_unit.sv @@
// Top level of the sorted key table: cell chain, sequencing and result register.
//
// A table of up to CAPACITY entries (32-bit key, 32-bit value) kept in
// ascending key order in a row of cells, one entry per cell.
// Input channel: i_valid / o_stall carry one beat of command, key, value.
// Command insert stores the entry before any run of equal keys; command
// lookup returns the first entry whose key matches.
// Output channel: o_valid / i_stall carry one beat of status, position,
// value_out per input beat.
// Timing: at the accept edge every cell compares its key with the incoming
// key; in the update state each cell finds from its lower neighbor whether it
// is the lower-bound position, the insert shift happens in every cell at
// once, and the result is registered. A new item is accepted only once the
// last one has left the update state; the result timing is set by the compare
// and the update step of the cell row, independent of CAPACITY.
// While a result waits under i_stall, the next item is still accepted and
// compared; its update cycle holds until the output register is free.
// Reset empties the table at once (valid flags only) and drops any result.
module sorted_key_table_unit
    import skt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [POS_W-1:0]  o_position,
    output logic [VAL_W-1:0]  o_value_out
);

    t_state            r_state, n_state;
    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;

    logic              r_o_valid, n_o_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [VAL_W-1:0]  r_vout, n_vout;

    logic              w_accept;
    logic              w_out_free;
    logic              w_load;
    logic              w_full;
    logic              w_any_hit;
    logic [IDX_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_hit_value;
    t_cell_ctl         w_ctl;

    logic [KEY_W-1:0]  w_key   [CAPACITY];
    logic [VAL_W-1:0]  w_val   [CAPACITY];
    t_cell_stat        w_stat  [CAPACITY];

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_full     = w_stat[CAPACITY-1].valid;

    // ---- sequencing ----
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold the item for its update cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    assign w_ctl.cmp = w_accept;
    assign w_ctl.upd = w_load && (r_cmd == CMD_INSERT) && !w_full;

    // ---- cell row ----
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_prev_key;
        logic [VAL_W-1:0] w_prev_val;
        t_cell_stat       w_prev_stat;

        if (g == 0) begin : g_head
            // below the first cell every key counts as smaller
            assign w_prev_key  = '0;
            assign w_prev_val  = '0;
            assign w_prev_stat = '{valid: 1'b1, lt: 1'b1, eq: 1'b0, bnd: 1'b0};
        end else begin : g_link
            assign w_prev_key  = w_key[g-1];
            assign w_prev_val  = w_val[g-1];
            assign w_prev_stat = w_stat[g-1];
        end

        skt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_cmp_key   (i_key),
            .i_new_key   (r_key),
            .i_new_value (r_value),
            .i_prev_key  (w_prev_key),
            .i_prev_value(w_prev_val),
            .i_prev_stat (w_prev_stat),
            .o_key       (w_key[g]),
            .o_value     (w_val[g]),
            .o_stat      (w_stat[g])
        );
    end

    // ---- result: one-hot boundary to index, AND-OR of the hit value ----
    always_comb begin
        w_pos       = '0;
        w_hit_value = '0;
        w_any_hit   = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_stat[i].bnd) begin
                w_pos = w_pos | IDX_W'(i);
            end
            if (w_stat[i].bnd && w_stat[i].eq) begin
                w_hit_value = w_hit_value | w_val[i];
                w_any_hit   = 1'b1;
            end
        end
        // every cell below the key: position is past the last cell
        if (w_stat[CAPACITY-1].lt) begin
            w_pos = IDX_W'(CAPACITY);
        end
    end

    always_comb begin
        n_status = ST_MISS;
        n_vout   = '0;
        if (r_cmd == CMD_INSERT) begin
            n_status = w_full ? ST_FULL : ST_OK;
        end else if (w_any_hit) begin
            n_status = ST_OK;
            n_vout   = w_hit_value;
        end
        n_pos = POS_W'(w_pos);
    end

    assign n_o_valid = w_load || (r_o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_vout   <= n_vout;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_status    = r_status;
    assign o_position  = r_pos;
    assign o_value_out = r_vout;

endmodule

@@ tb/sv/tb_sorted_key_table_unit.sv @@
// Self-checking testbench for sorted_key_table_unit: random traffic and stalls vs a shadow table.
module tb_sorted_key_table_unit
    import skt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One request beat on the input side.
    typedef struct {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_request;

    // One expected result beat on the output side.
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value_out;
    } t_outcome;

    localparam int RANDOM_ITEMS = 1230;
    localparam int HOLD_CYCLES  = 60;   // long receiver hold-off, fills the pipeline

    // DUT ports: every input is known from time zero.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              i_command   = CMD_INSERT;
    logic [KEY_W-1:0]  i_key       = '0;
    logic [VAL_W-1:0]  i_value     = '0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [POS_W-1:0]  o_position;
    logic [VAL_W-1:0]  o_value_out;

    sorted_key_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_value_out (o_value_out)
    );

    // Shadow copy of the sorted table, updated in acceptance order.
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [VAL_W-1:0] shadow_vals [CAPACITY];
    int unsigned      shadow_count = 0;

    t_request    request_q [$];          // beats waiting to be offered
    t_outcome    pending_outcomes [$];   // results owed by the block, oldest first
    logic [KEY_W-1:0] planned_keys [$];  // keys that will end up stored, for lookup hits

    int unsigned planned_inserts = 0;
    int unsigned mismatches      = 0;
    int unsigned beats_in        = 0;
    int unsigned beats_out       = 0;
    int unsigned n_stored        = 0;
    int unsigned n_refused       = 0;
    int unsigned n_hits          = 0;
    int unsigned n_misses        = 0;
    int unsigned top_position    = 0;

    // Driver and receiver pacing state.
    int unsigned tx_gap        = 0;
    bit          tx_calm       = 1'b0;
    int unsigned rx_hold       = 0;
    bit          rx_calm       = 1'b0;
    int unsigned rx_seen       = 0;
    int unsigned next_long_hold = 150;
    t_request    next_req;
    t_outcome    want;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Pick an idle run: mostly none or short, now and then long.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)    return 0;
        if (r < 55)  return 0;
        if (r < 85)  return $urandom_range(1, 3);
        if (r < 97)  return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Apply one accepted beat to the shadow table and return the result it owes.
    function automatic t_outcome predict_outcome(logic cmd, logic [KEY_W-1:0] key,
                                                 logic [VAL_W-1:0] value);
        t_outcome    res;
        int unsigned slot;
        slot = shadow_count;
        // lower bound: first stored key not below the search key
        for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_keys[i] >= key) slot = i;
        end
        res.position  = slot[POS_W-1:0];
        res.value_out = '0;
        if (slot > top_position) top_position = slot;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = ST_FULL;
                n_refused++;
            end else begin
                // shift the tail up one place, then drop the entry in
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_vals[i] = shadow_vals[i-1];
                end
                shadow_keys[slot] = key;
                shadow_vals[slot] = value;
                shadow_count++;
                res.status = ST_OK;
                n_stored++;
            end
        end else if (slot < shadow_count && shadow_keys[slot] == key) begin
            res.status    = ST_OK;
            res.value_out = shadow_vals[slot];
            n_hits++;
        end else begin
            res.status = ST_MISS;
            n_misses++;
        end
        return res;
    endfunction

    function automatic void add_request(logic cmd, logic [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value);
        t_request req;
        req.command = cmd;
        req.key     = key;
        req.value   = value;
        request_q.push_back(req);
        if (cmd == CMD_INSERT) begin
            if (planned_inserts < CAPACITY) planned_keys.push_back(key);
            planned_inserts++;
        end
    endfunction

    // Random key for an insert: fresh, clustered, duplicate, extreme or neighbor.
    function automatic logic [KEY_W-1:0] insert_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40 || planned_keys.size() == 0) return $urandom;
        if (r < 60) return $urandom_range(0, 7);
        if (r < 80) return planned_keys[$urandom_range(0, planned_keys.size() - 1)];
        if (r < 90) return $urandom_range(0, 1) ? '1 : '0;
        return planned_keys[$urandom_range(0, planned_keys.size() - 1)] + 1;
    endfunction

    // Random key for a lookup: mostly stored keys, some near misses, some noise.
    function automatic logic [KEY_W-1:0] lookup_key();
        int unsigned      r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (planned_keys.size() == 0 || r >= 65) begin
            if (r >= 95) return $urandom_range(0, 1) ? '1 : '0;
            return $urandom;
        end
        k = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
        if (r < 50) return k;
        return $urandom_range(0, 1) ? k + 1 : k - 1;
    endfunction

    task automatic build_requests();
        // Directed: empty table, key and value extremes, a run of equal keys.
        add_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        add_request(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        add_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
        add_request(CMD_INSERT, 32'h8000_0000, 32'h5555_5555);
        add_request(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        add_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        add_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        add_request(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        add_request(CMD_LOOKUP, 32'h8000_0001, 32'h0000_0000);
        add_request(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000);
        add_request(CMD_INSERT, 32'h8000_0000, 32'h1234_5678);
        add_request(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        add_request(CMD_INSERT, 32'h0000_0000, 32'h8765_4321);
        add_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        add_request(CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000);

        // Random: inserts until the table fills and then get refused, lookups throughout.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 30) begin
                add_request(CMD_INSERT, insert_key(), $urandom);
            end else begin
                add_request(CMD_LOOKUP, lookup_key(), $urandom);
            end
        end
    endtask

    // Driver: predict on each accepted beat, hold while stalled, pace with gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pending_outcomes.push_back(predict_outcome(i_command, i_key, i_value));
                beats_in++;
            end
            if (i_valid && o_stall) begin
                // hold the stalled beat as it is
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                next_req = request_q.pop_front();
                i_command <= next_req.command;
                i_key     <= next_req.key;
                i_value   <= next_req.value;
                i_valid   <= 1'b1;
                if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
                tx_gap = pick_gap(tx_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: random stalls, calm stretches, and periodic long hold-offs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) rx_seen++;
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_seen >= next_long_hold) begin
                // starve the output long enough for the block to push back on its input
                next_long_hold += 400;
                rx_hold = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
                rx_hold = pick_gap(1'b0);
                i_stall <= (rx_hold > 0);
                if (rx_hold > 0) rx_hold--;
            end else begin
                if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
                i_stall <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing expected: status %0d position %0d value_out %h",
                       o_status, o_position, o_value_out);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    mismatches++;
                end
                if (o_value_out !== want.value_out) begin
                    $error("value_out: expected %h, got %h", want.value_out, o_value_out);
                    mismatches++;
                end
            end
        end
    end

    // Reset, stimulus, drain and verdict.
    initial begin
        build_requests();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (request_q.size() == 0 && !i_valid && pending_outcomes.size() == 0);
        // let any stray beat show up before the verdict
        repeat (10) @(posedge i_clk);
        $display("Covered %0d beats in, %0d out: %0d stored, %0d refused on a full table,",
                 beats_in, beats_out, n_stored, n_refused);
        $display("%0d lookup hits, %0d misses, highest position %0d.",
                 n_hits, n_misses, top_position);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sorted_key_table_unit.f @@
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_unit.sv
tb/sv/tb_sorted_key_table_unit.sv
